// ----- rtl/psg_pkg.sv -----
// ----------------------------------------------------------------------------
// PSG package
// Shared types, constants and the attenuation level table for the sound
// generator.
// ----------------------------------------------------------------------------
package psg_pkg;

	// Function codes carried in the command request.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	// Noise rate codes (low two bits of the noise control register).
	localparam logic [1:0] NOISE_RATE_16   = 2'd0;
	localparam logic [1:0] NOISE_RATE_32   = 2'd1;
	localparam logic [1:0] NOISE_RATE_64   = 2'd2;
	localparam logic [1:0] NOISE_RATE_TONE = 2'd3;

	// Latched channel number of the noise channel.
	localparam logic [1:0] NOISE_CHANNEL = 2'd3;

	localparam logic [15:0] NOISE_SEED  = 16'h8000;
	localparam logic [15:0] STEP_CYCLES = 16'd16;
	localparam logic [9:0]  MIN_PERIOD  = 10'd6;

	typedef logic signed [10:0] counter_t;
	typedef logic signed [16:0] amp_t;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
		logic [7:0] cycle_count;
		logic [7:0] stereo_mask;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
	} sample_t;

	typedef struct packed {
		logic game_gear_mode;
	} cfg_t;

	// Output level for an inverted attenuation code (15 is loudest).
	function automatic logic [14:0] level_of(input logic [3:0] idx);
		logic [14:0] lv;
		begin
			case (idx)
				4'd0:    lv = 15'd0;
				4'd1:    lv = 15'd1304;
				4'd2:    lv = 15'd1642;
				4'd3:    lv = 15'd2067;
				4'd4:    lv = 15'd2603;
				4'd5:    lv = 15'd3277;
				4'd6:    lv = 15'd4125;
				4'd7:    lv = 15'd5193;
				4'd8:    lv = 15'd6568;
				4'd9:    lv = 15'd8231;
				4'd10:   lv = 15'd10362;
				4'd11:   lv = 15'd13045;
				4'd12:   lv = 15'd16422;
				4'd13:   lv = 15'd20675;
				4'd14:   lv = 15'd26028;
				4'd15:   lv = 15'd32767;
				default: lv = 15'd0;
			endcase
			return lv;
		end
	endfunction

endpackage

// ----- rtl/psg_stream_if.sv -----
// ----------------------------------------------------------------------------
// PSG stream interface
// Valid/ready channel with a payload whose type is chosen per instance.
// ----------------------------------------------------------------------------
interface psg_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/psg_tone_noise_generator.sv -----
// ----------------------------------------------------------------------------
// PSG tone and noise generator
// Three square-wave tone channels and one noise channel, programmed by
// latch/data bytes and stepped by CPU cycle ticks, with a stereo mixer.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                                   Meaning
//   cmd      in         func, data_byte, cycle_count, stereo_mask register byte or tick
//   cfg      in         game_gear_mode                            mixer mode register
//   smp      out        left_sample, right_sample                 one mixed sample
//
// An accepted request is held in one input register; when it moves on, the
// short update logic applies it to the channel state and, for a tick that
// brings the cycle accumulator to STEP_CYCLES, loads one sample into the output register.
// A request may be accepted in every cycle while the input register does not
// stall, so the rate is one request per cycle unless a stall holds it.
// The input register stalls only while it holds a sample-producing tick and
// the output register is still full and not being taken.
// Reset (arst_n low) silences all channels and clears the accumulator.
// The configuration channel is always ready.
//
module psg_tone_noise_generator (
	input  logic         clk,
	input  logic         arst_n,
	psg_stream_if.sink   cmd,
	psg_stream_if.sink   cfg,
	psg_stream_if.source smp
);
	import psg_pkg::*;

	// Input stage.
	logic valid_s1;
	cmd_t cmd_s1;

	// Configuration.
	logic gg_mode_q;

	// Channel state.
	logic [3:0]  atten_q  [4];
	logic [9:0]  period_q [3];
	logic [3:0]  noise_ctrl_q;
	counter_t    cnt_q    [4];
	logic        pol_q    [4];
	logic        nbit_q;
	logic [15:0] shifter_q;
	logic [1:0]  latch_ch_q;
	logic        att_sel_q;
	logic [15:0] acc_q;

	// Output register.
	logic    smp_valid_q;
	sample_t smp_q;

	// Next-state values computed from the input register.
	logic [3:0]  atten_d  [4];
	logic [9:0]  period_d [3];
	logic [3:0]  noise_ctrl_d;
	counter_t    cnt_d    [4];
	logic        pol_d    [4];
	logic        nbit_d;
	logic [15:0] shifter_d;
	logic [1:0]  latch_ch_d;
	logic        att_sel_d;
	logic [15:0] acc_d;
	logic        step;
	sample_t     smp_d;

	logic out_free;
	logic adv_s1;

	// The held request moves on unless it would produce a sample that has
	// nowhere to go.
	assign out_free  = !smp_valid_q || smp.ready;
	assign adv_s1    = valid_s1 && (!step || out_free);
	assign cmd.ready = !valid_s1 || adv_s1;
	assign cfg.ready = 1'b1;

	assign smp.valid   = smp_valid_q;
	assign smp.payload = smp_q;

	// Halve with truncation towards zero, then clamp to sixteen bits.
	function automatic logic signed [15:0] halve_clamp(input logic signed [18:0] sum);
		logic signed [17:0] v;
		begin
			v = 18'((sum + $signed({18'd0, sum[18]})) >>> 1);
			if (v > 18'sd32767) begin
				return 16'sh7FFF;
			end else if (v < -18'sd32768) begin
				return 16'sh8000;
			end
			return v[15:0];
		end
	endfunction

	always_comb begin
		logic [7:0]        b;
		logic [1:0]        ch;
		logic              att;
		logic [9:0]        p;
		logic [16:0]       acc_sum;
		logic [15:0]       acc_sat;
		logic              fb;
		amp_t              amp   [4];
		logic [14:0]       lv;
		logic signed [18:0] l_sum;
		logic signed [18:0] r_sum;
		logic signed [18:0] m_sum;
		counter_t          dec;

		for (int i = 0; i < 4; i++) begin
			atten_d[i] = atten_q[i];
			cnt_d[i]   = cnt_q[i];
			pol_d[i]   = pol_q[i];
		end
		for (int i = 0; i < 3; i++) begin
			period_d[i] = period_q[i];
		end
		noise_ctrl_d = noise_ctrl_q;
		nbit_d       = nbit_q;
		shifter_d    = shifter_q;
		latch_ch_d   = latch_ch_q;
		att_sel_d    = att_sel_q;
		acc_d        = acc_q;
		step         = 1'b0;
		fb           = 1'b0;
		dec          = '0;

		// Register byte: a latch byte (top bit set) picks the channel and
		// register, then both byte forms write the selected register.
		b   = cmd_s1.data_byte;
		ch  = b[7] ? b[6:5] : latch_ch_q;
		att = b[7] ? b[4] : att_sel_q;
		p   = b[7] ? {period_q[2][9:4], b[3:0]} : {b[5:0], period_q[2][3:0]};
		if (ch != NOISE_CHANNEL) begin
			p = b[7] ? {period_q[ch][9:4], b[3:0]} : {b[5:0], period_q[ch][3:0]};
		end
		if (p < MIN_PERIOD) begin
			p = '0;
		end

		// Tick: saturating cycle accumulator.
		acc_sum = {1'b0, acc_q} + {9'd0, cmd_s1.cycle_count};
		acc_sat = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];

		if (cmd_s1.func == FUNC_WRITE) begin
			latch_ch_d = ch;
			att_sel_d  = att;
			if (att) begin
				atten_d[ch] = b[3:0];
			end else if (ch == NOISE_CHANNEL) begin
				noise_ctrl_d = b[3:0];
				shifter_d    = NOISE_SEED;
			end else begin
				period_d[ch] = p;
			end
		end else begin
			step  = (acc_sat >= STEP_CYCLES);
			acc_d = step ? acc_sat - STEP_CYCLES : acc_sat;
		end

		// Noise channel: reload its counter and clock the shifter on every
		// second expiry.
		if (step && (cnt_q[3] <= 11'sd0)) begin
			case (noise_ctrl_q[1:0])
				NOISE_RATE_16:   cnt_d[3] = 11'sd16;
				NOISE_RATE_32:   cnt_d[3] = 11'sd32;
				NOISE_RATE_64:   cnt_d[3] = 11'sd64;
				NOISE_RATE_TONE: cnt_d[3] = $signed({1'b0, period_q[2]});
				default:         cnt_d[3] = 11'sd16;
			endcase
			if (!pol_q[3]) begin
				pol_d[3]  = 1'b1;
				nbit_d    = shifter_q[0];
				fb        = noise_ctrl_q[2] ? (shifter_q[0] ^ shifter_q[3]) : shifter_q[0];
				shifter_d = {fb, shifter_q[15:1]};
			end else begin
				pol_d[3] = 1'b0;
			end
		end

		// Channel amplitudes: tones swing around zero, noise is zero or up.
		for (int i = 0; i < 3; i++) begin
			lv     = level_of(~atten_q[i]);
			amp[i] = pol_q[i] ? $signed({2'b00, lv}) : -$signed({2'b00, lv});
		end
		lv     = level_of(~atten_q[3]);
		amp[3] = nbit_d ? $signed({2'b00, lv}) : '0;

		l_sum = '0;
		r_sum = '0;
		for (int i = 0; i < 4; i++) begin
			if (cmd_s1.stereo_mask[4 + i]) begin
				l_sum = l_sum + 19'(amp[i]);
			end
			if (cmd_s1.stereo_mask[i]) begin
				r_sum = r_sum + 19'(amp[i]);
			end
		end
		m_sum = 19'(amp[0]) + 19'(amp[1]) + 19'(amp[2]) + 19'(amp[3]);

		if (gg_mode_q) begin
			smp_d.left_sample  = halve_clamp(l_sum);
			smp_d.right_sample = halve_clamp(r_sum);
		end else begin
			smp_d.left_sample  = halve_clamp(m_sum);
			smp_d.right_sample = halve_clamp(m_sum);
		end

		// Count down all channels; tone channels flip polarity on expiry,
		// and a tone with a zero period is held high.
		if (step) begin
			cnt_d[3] = cnt_d[3] - 11'sd1;
			for (int i = 0; i < 3; i++) begin
				dec = cnt_q[i] - 11'sd1;
				if (dec <= 11'sd0) begin
					cnt_d[i] = $signed({1'b0, period_q[i]});
					pol_d[i] = !(pol_q[i] && (period_q[i] != 10'd0));
				end else begin
					cnt_d[i] = dec;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gg_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			gg_mode_q <= cfg.payload.game_gear_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				atten_q[i] <= 4'hF;
				cnt_q[i]   <= '0;
				pol_q[i]   <= 1'b1;
			end
			for (int i = 0; i < 3; i++) begin
				period_q[i] <= '0;
			end
			noise_ctrl_q <= '0;
			nbit_q       <= 1'b0;
			shifter_q    <= '0;
			latch_ch_q   <= '0;
			att_sel_q    <= 1'b0;
			acc_q        <= '0;
		end else if (adv_s1) begin
			for (int i = 0; i < 4; i++) begin
				atten_q[i] <= atten_d[i];
				cnt_q[i]   <= cnt_d[i];
				pol_q[i]   <= pol_d[i];
			end
			for (int i = 0; i < 3; i++) begin
				period_q[i] <= period_d[i];
			end
			noise_ctrl_q <= noise_ctrl_d;
			nbit_q       <= nbit_d;
			shifter_q    <= shifter_d;
			latch_ch_q   <= latch_ch_d;
			att_sel_q    <= att_sel_d;
			acc_q        <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid_q <= 1'b0;
		end else if (adv_s1 && step) begin
			smp_valid_q <= 1'b1;
		end else if (smp.ready) begin
			smp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && step) begin
			smp_q <= smp_d;
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PSG tone and noise generator testbench
// Drives latch/data bytes and CPU cycle ticks into the sound generator,
// keeps a shadow of the chip state, and checks every stereo sample field by
// field under mono and stereo mixing and under varied back-pressure.
// ----------------------------------------------------------------------------
module testbench;
	import psg_pkg::*;

	localparam int TIMEOUT_NS      = 2_000_000;
	// The sample register is loaded from the request register once it moves on;
	// the spare settle cycles also cover a request that produces no sample at all.
	localparam int SETTLE_CYCLES   = 4;
	localparam int NOISE_WHITE_BIT = 2;

	// Output level against the inverted attenuation, loudest last.
	localparam int LEVEL_LUT [16] = '{
		0, 1304, 1642, 2067, 2603, 3277, 4125, 5193,
		6568, 8231, 10362, 13045, 16422, 20675, 26028, 32767
	};

	logic clk;
	logic arst_n;

	psg_stream_if #(.payload_t(cmd_t))    cmd_if ();
	psg_stream_if #(.payload_t(cfg_t))    cfg_if ();
	psg_stream_if #(.payload_t(sample_t)) smp_if ();

	psg_tone_noise_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.cfg    (cfg_if),
		.smp    (smp_if)
	);

	// Shadow copy of the chip. It is advanced at the moment each request is
	// accepted, so the queue below always holds the samples still owed.
	logic        stereo_mode = 1'b0;
	logic [3:0]  atten [4] = '{default: 4'hF};
	logic [9:0]  tone_period [3] = '{default: 10'd0};
	logic [3:0]  noise_ctl = 4'd0;
	int          divider [4] = '{default: 0};
	bit          polarity [4] = '{default: 1'b1};
	logic        noise_out = 1'b0;
	logic [15:0] noise_lfsr = 16'd0;
	logic [1:0]  latch_ch = 2'd0;
	logic        latch_atten = 1'b0;
	logic [15:0] backlog_cycles = 16'd0;
	int          saturation_hits = 0;

	sample_t pending_samples [$];
	int      mismatches = 0;

	// Percentages of cycles in which the sender holds off and the sample
	// receiver withholds ready.
	int send_idle_pct  = 20;
	int recv_stall_pct = 83;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("[psg_tone_noise_generator] ERROR");
		$finish;
	end

	function automatic logic signed [15:0] halve_and_saturate(input int total);
		int half;
		half = total / 2;
		if (half > 32767)
			half = 32767;
		else if (half < -32768)
			half = -32768;
		return half[15:0];
	endfunction

	// A latch byte (bit 7 set) picks the channel and whether the attenuation
	// or the tone/noise register is addressed; a data byte reuses that choice.
	task automatic write_chip_byte(input logic [7:0] b);
		logic [9:0] p;
		if (b[7]) begin
			latch_ch    = b[6:5];
			latch_atten = b[4];
		end
		if (latch_atten) begin
			atten[latch_ch] = b[3:0];
		end else if (latch_ch == NOISE_CHANNEL) begin
			noise_ctl  = b[3:0];
			noise_lfsr = NOISE_SEED;
		end else begin
			p = tone_period[latch_ch];
			if (b[7])
				p[3:0] = b[3:0];
			else
				p[9:4] = b[5:0];
			// Periods too short to be audible are cut to zero, which holds the channel high.
			if (p < MIN_PERIOD)
				p = '0;
			tone_period[latch_ch] = p;
		end
	endtask

	task automatic run_sound_step(input logic [7:0] mask, output sample_t s);
		int   amp [4];
		int   left_sum;
		int   right_sum;
		logic fb;
		left_sum  = 0;
		right_sum = 0;
		// The noise divider reloads before the mix; the shifter only moves on
		// every second expiry, when the noise polarity goes positive.
		if (divider[3] <= 0) begin
			case (noise_ctl[1:0])
				NOISE_RATE_16: divider[3] = 16;
				NOISE_RATE_32: divider[3] = 32;
				NOISE_RATE_64: divider[3] = 64;
				default:       divider[3] = int'(tone_period[2]);
			endcase
			if (!polarity[3]) begin
				polarity[3] = 1'b1;
				noise_out   = noise_lfsr[0];
				fb = noise_ctl[NOISE_WHITE_BIT] ? (noise_lfsr[0] ^ noise_lfsr[3])
				                                : noise_lfsr[0];
				noise_lfsr  = {fb, noise_lfsr[15:1]};
			end else begin
				polarity[3] = 1'b0;
			end
		end
		for (int i = 0; i < 3; i++)
			amp[i] = polarity[i] ? LEVEL_LUT[~atten[i]] : -LEVEL_LUT[~atten[i]];
		amp[3] = noise_out ? LEVEL_LUT[~atten[3]] : 0;
		if (stereo_mode) begin
			for (int i = 0; i < 4; i++) begin
				if (mask[4 + i])
					left_sum += amp[i];
				if (mask[i])
					right_sum += amp[i];
			end
			s.left_sample  = halve_and_saturate(left_sum);
			s.right_sample = halve_and_saturate(right_sum);
		end else begin
			s.left_sample  = halve_and_saturate(amp[0] + amp[1] + amp[2] + amp[3]);
			s.right_sample = s.left_sample;
		end
		// All dividers count down after the mix; a silenced channel is
		// forced back to positive polarity on every reload.
		for (int i = 0; i < 4; i++)
			divider[i]--;
		for (int i = 0; i < 3; i++) begin
			if (divider[i] <= 0) begin
				divider[i]  = int'(tone_period[i]);
				polarity[i] = !(polarity[i] && tone_period[i] != 10'd0);
			end
		end
	endtask

	task automatic psg_update(input cmd_t req);
		int      total;
		sample_t s;
		if (req.func == FUNC_WRITE) begin
			write_chip_byte(req.data_byte);
			return;
		end
		total = int'(backlog_cycles) + int'(req.cycle_count);
		if (total > 32'hFFFF) begin
			total = 32'hFFFF;
			saturation_hits++;
		end
		if (total < int'(STEP_CYCLES)) begin
			backlog_cycles = total[15:0];
			return;
		end
		backlog_cycles = 16'(total - int'(STEP_CYCLES));
		run_sound_step(req.stereo_mask, s);
		pending_samples.push_back(s);
	endtask

	// Fields that the block ignores for a given function still get random
	// values, so every input bit moves.
	function automatic cmd_t make_write(input logic [7:0] b);
		cmd_t c;
		c.func        = FUNC_WRITE;
		c.data_byte   = b;
		c.cycle_count = 8'($urandom);
		c.stereo_mask = 8'($urandom);
		return c;
	endfunction

	function automatic cmd_t make_tick(input logic [7:0] cycles, input logic [7:0] mask);
		cmd_t c;
		c.func        = FUNC_TICK;
		c.data_byte   = 8'($urandom);
		c.cycle_count = cycles;
		c.stereo_mask = mask;
		return c;
	endfunction

	// Valid stays high after an acceptance so that back-to-back requests never
	// lower and raise it in the same step; anything that stops sending lowers
	// it through wait_for_idle.
	task automatic send_request(input cmd_t req);
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		cmd_if.valid   <= 1'b1;
		cmd_if.payload <= req;
		do
			@(posedge clk);
		while (!cmd_if.ready);
		psg_update(req);
	endtask

	task automatic wait_for_idle();
		cmd_if.valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mixer_mode(input logic mode);
		cfg_t word;
		wait_for_idle();
		word.game_gear_mode = mode;
		cfg_if.valid   <= 1'b1;
		cfg_if.payload <= word;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		stereo_mode = mode;
	endtask

	// Straight out of reset every channel is silent, so the first sample is
	// zero; the accumulator must reach STEP_CYCLES before it appears.
	task automatic test_power_up_silence();
		send_request(make_tick(8'd15, 8'hFF));
		send_request(make_tick(8'd0, 8'h00));
		send_request(make_tick(8'd1, 8'hFF));
		send_request(make_write(8'hFF));
		send_request(make_tick(8'd255, 8'h00));
	endtask

	// Both halves of a tone period, a period cut to zero for being short,
	// the shortest period kept, and three loud channels driving the mix into
	// its positive limit.
	task automatic test_tone_programming();
		send_request(make_write(8'h85));
		send_request(make_write(8'h3F));
		send_request(make_write(8'h90));
		send_request(make_write(8'hA3));
		send_request(make_write(8'h00));
		send_request(make_write(8'hB0));
		send_request(make_write(8'hC6));
		send_request(make_write(8'h00));
		send_request(make_write(8'hD0));
		repeat (4) send_request(make_tick(8'd16, 8'hFF));
		send_request(make_write(8'h80));
		send_request(make_write(8'h7F));
		send_request(make_tick(8'd16, 8'h0F));
	endtask

	// Noise clocked from a zero tone 2 period toggles on every step; then a
	// data byte rewrites the noise control while noise is latched, selecting
	// white feedback with the unused top bit set.
	task automatic test_noise_channel();
		send_request(make_write(8'hC0));
		send_request(make_write(8'hE7));
		send_request(make_write(8'hF0));
		repeat (3) send_request(make_tick(8'd16, 8'hF0));
		send_request(make_write(8'hE0));
		send_request(make_write(8'h0C));
		repeat (2) send_request(make_tick(8'd20, 8'h88));
	endtask

	// Mostly meaningful latch/data pairs with short periods, so polarities
	// flip within a run of this length, mixed with ticks and raw bytes.
	task automatic test_random_traffic(input int count);
		int         pick;
		logic [7:0] latch;
		for (int n = 0; n < count; n++) begin
			// Hold the sender back once mid-run until every owed sample is in.
			if (n == count / 2)
				wait_for_idle();
			pick = $urandom_range(99);
			if (pick < 50) begin
				if ($urandom_range(7) == 0)
					send_request(make_tick(8'($urandom), 8'($urandom)));
				else
					send_request(make_tick(8'($urandom_range(32)), 8'($urandom)));
			end else if (pick < 60) begin
				send_request(make_write(8'($urandom)));
			end else begin
				latch = {1'b1, 2'($urandom), 1'($urandom), 4'($urandom)};
				send_request(make_write(latch));
				if (!latch[4] && $urandom_range(3) != 0) begin
					if ($urandom_range(2) == 0)
						send_request(make_write({1'b0, 7'($urandom)}));
					else
						send_request(make_write({1'b0, 7'($urandom_range(3))}));
				end
			end
		end
	endtask

	// Full-size ticks outrun the one step per tick, so the accumulator climbs
	// until it pins at its ceiling; a few writes keep the channels moving.
	task automatic test_backlog_saturation();
		while (saturation_hits < 3) begin
			if ($urandom_range(7) == 0)
				send_request(make_write(8'($urandom)));
			else
				send_request(make_tick(8'd255, 8'($urandom)));
		end
	endtask

	// Samples leave under a randomly withheld ready.
	always @(posedge clk) begin
		smp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		sample_t want;
		sample_t got;
		if (arst_n && smp_if.valid && smp_if.ready) begin
			got = smp_if.payload;
			if (pending_samples.size() == 0) begin
				$display("%0t: sample with none expected, got left %0d right %0d",
				         $time, got.left_sample, got.right_sample);
				mismatches++;
			end else begin
				want = pending_samples.pop_front();
				if (got.left_sample !== want.left_sample) begin
					$display("%0t: left_sample expected %0d, got %0d",
					         $time, want.left_sample, got.left_sample);
					mismatches++;
				end
				if (got.right_sample !== want.right_sample) begin
					$display("%0t: right_sample expected %0d, got %0d",
					         $time, want.right_sample, got.right_sample);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n         <= 1'b0;
		cmd_if.valid   <= 1'b0;
		cmd_if.payload <= '0;
		cfg_if.valid   <= 1'b0;
		cfg_if.payload <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_mixer_mode(1'b0);
		test_power_up_silence();
		test_tone_programming();
		test_noise_channel();

		set_mixer_mode(1'b1);
		test_random_traffic(35);

		set_mixer_mode(1'b0);
		send_idle_pct  = 83;
		recv_stall_pct = 20;
		test_random_traffic(35);

		set_mixer_mode(1'b1);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_traffic(35);
		test_backlog_saturation();

		wait_for_idle();
		if (mismatches == 0)
			$display("[psg_tone_noise_generator] OK");
		else
			$display("[psg_tone_noise_generator] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/psg_pkg.sv
rtl/psg_stream_if.sv
rtl/psg_tone_noise_generator.sv
tb/sv/testbench.sv
